// ===== rtl/qnps_pkg.sv =====
// Shared types, constants and lookup functions for the quadrature needle position servo.
// No dependencies; every other file in rtl/ imports this package.
package qnps_pkg;

    // Position counter width and the exact-error width derived from it
    localparam int CNT_W = 32;
    localparam int ERR_W = CNT_W + 2;

    // Fixed servo constants
    localparam int NEEDLE_ZERO = 32767;
    localparam int RATE_FULL   = 6000;
    localparam int STOP_TOL    = 5;
    localparam int WIN_MIN     = 5;

    // Shared divider: 24-bit dividend, divisor 1, 105, 500, 1000 or 2000,
    // quotient by one reciprocal multiplication
    localparam int DIV_NW    = 24;
    localparam int DIV_DW    = 11;
    localparam int DIV_STEPS = 1;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    // Reciprocals: x/105 = (x * RECIP_105) >> 30 and x/125 = (x * RECIP_125) >> 27,
    // exact for any 24-bit x; 500, 1000 and 2000 pre-shift x by 2, 3 and 4
    localparam int RECIP_W      = 48;
    localparam int RECIP_105    = 10226113;
    localparam int RECIP_105_SH = 30;
    localparam int RECIP_125    = 1073742;
    localparam int RECIP_125_SH = 27;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SERVO_ENABLE   = 3'd0,
        CFG_ENCODER_INVERT = 3'd1,
        CFG_UPPER_LIMIT    = 3'd2,
        CFG_LOWER_LIMIT    = 3'd3,
        CFG_HALF_RANGE     = 3'd4,
        CFG_FULL_LEVEL     = 3'd5,
        CFG_APPROACH_LEVEL = 3'd6
    } t_cfg_idx;

    localparam int CFG_DW = 16;

    // Action codes of an input item
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_COMMAND = 1'b1;

    // Input transaction payload
    typedef struct packed {
        logic        action;
        logic        enc_a;
        logic        enc_b;
        logic [15:0] needle;
    } t_in_item;

    // Output transaction payload
    typedef struct packed {
        logic [9:0]         drive_fwd;
        logic [9:0]         drive_rev;
        logic signed [31:0] position;
        logic signed [31:0] target;
    } t_out_item;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_RATE,
        ST_RATE,
        ST_SEG,
        ST_MUL_LO,
        ST_DIV_LO,
        ST_MUL_HI,
        ST_DIV_HI,
        ST_MUL_INT,
        ST_DIV_INT,
        ST_GOAL,
        ST_CLAMP,
        ST_ERR,
        ST_LEVEL,
        ST_DONE
    } t_state;

    // Which product feeds the divider
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LO,
        MUL_HI,
        MUL_INT
    } t_mul_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     load_in;
        logic     decode;
        logic     mul_rate;
        logic     rate;
        logic     seg;
        t_mul_sel mul_sel;
        logic     div_step;
        logic     cap_lo;
        logic     cap_hi;
        logic     goal;
        logic     clamp;
        logic     err;
        logic     level;
        logic     out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic enable;
        logic div_done;
        logic out_free;
    } t_dp_sts;

    // Quadrature transition table, index {old_ab, new_ab}, two's complement step
    function automatic logic [1:0] step_of(input logic [3:0] idx);
        logic [1:0] s;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: s = 2'b11;
            4'd2, 4'd4, 4'd11, 4'd13: s = 2'b01;
            default: s = 2'b00;
        endcase
        return s;
    endfunction

    // Breakpoint rates of the needle curve
    function automatic logic [12:0] brk_rate(input logic [3:0] i);
        logic [12:0] r;
        case (i)
            4'd0: r = 13'd0;
            4'd1: r = 13'd500;
            4'd2: r = 13'd1000;
            4'd3: r = 13'd1500;
            4'd4: r = 13'd2000;
            4'd5: r = 13'd2500;
            4'd6: r = 13'd3000;
            4'd7: r = 13'd4000;
            default: r = 13'd6000;
        endcase
        return r;
    endfunction

    // Breakpoint fraction numerators (of half range)
    function automatic logic [6:0] brk_num(input logic [3:0] i);
        logic [6:0] n;
        case (i)
            4'd0: n = 7'd0;
            4'd1: n = 7'd13;
            4'd2: n = 7'd26;
            4'd3: n = 7'd39;
            4'd4: n = 7'd53;
            4'd5: n = 7'd59;
            4'd6: n = 7'd66;
            4'd7: n = 7'd79;
            default: n = 7'd1;
        endcase
        return n;
    endfunction

    // Breakpoint fraction denominators
    function automatic logic [6:0] brk_den(input logic [3:0] i);
        logic [6:0] d;
        case (i)
            4'd0: d = 7'd1;
            4'd8: d = 7'd1;
            default: d = 7'd105;
        endcase
        return d;
    endfunction

    // Segment of the curve: first one whose upper breakpoint is at or above rate
    function automatic logic [2:0] seg_of(input logic [12:0] rate);
        logic [2:0] s;
        s = 3'd7;
        for (int i = 6; i >= 0; i--) begin
            if (rate <= brk_rate(4'(i + 1))) begin
                s = 3'(i);
            end
        end
        return s;
    endfunction

endpackage

// ===== rtl/quadrature_needle_position_servo.sv =====
// Top level of the quadrature needle position servo.
// Depends on qnps_pkg, qnps_ctrl and qnps_datapath.

// One item is worked at a time and every item yields one result transaction. A tick
// (encoder sample) runs through decode, clamp, error and level states to a loaded result;
// a needle command with the servo enabled first walks the needle curve, and a disabled
// command goes straight to clamp. The enabled command time is set by the needle curve:
// three products (segment base, segment top and the interpolation step) each pass through
// a shared reciprocal divider. The controller returns to idle after the result is loaded
// and accepts the next item there; a result still waiting on o_out_valid holds the next
// result in the last state.
// Configuration writes take effect at once and should be made while the block is idle.
module quadrature_needle_position_servo import qnps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer
    qnps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_data.action),
        .o_in_stall  (o_in_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and state
    qnps_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // An accepted transaction closes the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // The motor is never driven in both directions at once
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.drive_fwd == 10'd0 || o_out_data.drive_rev == 10'd0))
        else $error("both drive outputs active");

    // No result survives a reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

// ===== rtl/qnps_ctrl.sv =====
// Sequencing state machine of the needle position servo.
// Depends on qnps_pkg; drives the datapath through t_dp_cmd and reads t_dp_sts.
module qnps_ctrl import qnps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_action,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_action == ACT_TICK) begin
                        n_state = ST_DECODE;
                    end else if (i_sts.enable) begin
                        n_state = ST_MUL_RATE;
                    end else begin
                        n_state = ST_CLAMP;
                    end
                end
            end
            ST_DECODE:   n_state = ST_CLAMP;
            ST_MUL_RATE: n_state = ST_RATE;
            ST_RATE:     n_state = ST_SEG;
            ST_SEG:      n_state = ST_MUL_LO;
            ST_MUL_LO:   n_state = ST_DIV_LO;
            ST_DIV_LO: begin
                if (i_sts.div_done) begin
                    n_state = ST_MUL_HI;
                end
            end
            ST_MUL_HI:   n_state = ST_DIV_HI;
            ST_DIV_HI: begin
                if (i_sts.div_done) begin
                    n_state = ST_MUL_INT;
                end
            end
            ST_MUL_INT:  n_state = ST_DIV_INT;
            ST_DIV_INT: begin
                if (i_sts.div_done) begin
                    n_state = ST_GOAL;
                end
            end
            ST_GOAL:     n_state = ST_CLAMP;
            ST_CLAMP:    n_state = ST_ERR;
            ST_ERR:      n_state = ST_LEVEL;
            ST_LEVEL:    n_state = ST_DONE;
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.mul_sel = MUL_NONE;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            ST_DECODE:   o_cmd.decode   = 1'b1;
            ST_MUL_RATE: o_cmd.mul_rate = 1'b1;
            ST_RATE:     o_cmd.rate     = 1'b1;
            ST_SEG:      o_cmd.seg      = 1'b1;
            ST_MUL_LO:   o_cmd.mul_sel  = MUL_LO;
            ST_DIV_LO: begin
                o_cmd.div_step = !i_sts.div_done;
                o_cmd.cap_lo   = i_sts.div_done;
            end
            ST_MUL_HI:   o_cmd.mul_sel  = MUL_HI;
            ST_DIV_HI: begin
                o_cmd.div_step = !i_sts.div_done;
                o_cmd.cap_hi   = i_sts.div_done;
            end
            ST_MUL_INT:  o_cmd.mul_sel  = MUL_INT;
            ST_DIV_INT:  o_cmd.div_step = !i_sts.div_done;
            ST_GOAL:     o_cmd.goal     = 1'b1;
            ST_CLAMP:    o_cmd.clamp    = 1'b1;
            ST_ERR:      o_cmd.err      = 1'b1;
            ST_LEVEL:    o_cmd.level    = 1'b1;
            ST_DONE:     o_cmd.out_load = i_sts.out_free;
            default:     o_in_stall     = 1'b1;
        endcase
    end

endmodule

// ===== rtl/qnps_datapath.sv =====
// Datapath of the needle position servo: config registers, decoder, position counter,
// needle curve arithmetic with a shared reciprocal divider, servo levels and output register.
// Depends on qnps_pkg; sequenced by qnps_ctrl.
module qnps_datapath import qnps_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  t_in_item                i_in_data,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_index,
    input  logic [CFG_DW-1:0]       i_cfg_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out_data
);

    // Configuration
    logic               r_enable;
    logic               r_invert;
    logic signed [15:0] r_upper;
    logic signed [15:0] r_lower;
    logic [14:0]        r_half;
    logic [9:0]         r_full;
    logic [9:0]         r_appr;

    // Servo state
    t_in_item           r_item;
    logic [1:0]         r_prev_ab;
    logic [CNT_W-1:0]   r_count;
    logic signed [15:0] r_goal;
    logic [9:0]         r_lvl_fwd;
    logic [9:0]         r_lvl_rev;

    // Needle curve working registers
    logic               r_neg;
    logic [27:0]        r_prod;
    logic [12:0]        r_rate;
    logic [2:0]         r_seg;
    logic [10:0]        r_dv;
    logic [15:0]        r_lo;
    logic [15:0]        r_hi;
    logic [ERR_W-1:0]   r_err;

    // Divider
    logic [DIV_DW-1:0]  r_div_d;
    logic [DIV_NW-1:0]  r_div_q;
    logic [DIV_CW-1:0]  r_div_cnt;

    // Output register
    logic               r_out_valid;
    t_out_item          r_out;

    // Next values
    logic [1:0]         n_cur_ab;
    logic [1:0]         n_step;
    logic [CNT_W-1:0]   n_count;
    logic               n_neg;
    logic [15:0]        n_abs_raw;
    logic [12:0]        n_q0;
    logic [15:0]        n_rem0;
    logic [12:0]        n_rate;
    logic [2:0]         n_seg;
    logic [3:0]         n_seg_lo;
    logic [3:0]         n_seg_hi;
    logic [DIV_NW-1:0]  n_dividend;
    logic [DIV_DW-1:0]  n_divisor;
    logic [RECIP_W-1:0] n_recip;
    logic [DIV_NW-1:0]  n_div_q;
    logic [15:0]        n_pos;
    logic signed [15:0] n_clamped;
    logic [ERR_W-1:0]   n_mag;
    logic [12:0]        n_win;
    logic [9:0]         n_lvl;
    logic               n_fwd;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_invert <= 1'b0;
            r_upper  <= '0;
            r_lower  <= '0;
            r_half   <= '0;
            r_full   <= 10'd1000;
            r_appr   <= 10'd550;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SERVO_ENABLE:   r_enable <= i_cfg_data[0];
                CFG_ENCODER_INVERT: r_invert <= i_cfg_data[0];
                CFG_UPPER_LIMIT:    r_upper  <= signed'(i_cfg_data[15:0]);
                CFG_LOWER_LIMIT:    r_lower  <= signed'(i_cfg_data[15:0]);
                CFG_HALF_RANGE:     r_half   <= i_cfg_data[14:0];
                CFG_FULL_LEVEL:     r_full   <= i_cfg_data[9:0];
                CFG_APPROACH_LEVEL: r_appr   <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Quadrature decode; step negated when inverted
    always_comb begin
        n_cur_ab = {r_item.enc_a, r_item.enc_b};
        n_step   = step_of({r_prev_ab, n_cur_ab});
        if (r_invert) begin
            n_step = 2'(-n_step);
        end
        n_count  = r_count + {{(CNT_W-2){n_step[1]}}, n_step};
    end

    // Needle offset magnitude and rate (divide by 32767 via shift and one correction)
    always_comb begin
        n_neg     = (r_item.needle < 16'(NEEDLE_ZERO));
        n_abs_raw = n_neg ? 16'(NEEDLE_ZERO) - r_item.needle
                          : r_item.needle - 16'(NEEDLE_ZERO);
        n_q0      = r_prod[27:15];
        n_rem0    = 16'(r_prod[14:0]) + 16'(n_q0);
        n_rate    = n_q0 + 13'(n_rem0 >= 16'(NEEDLE_ZERO));
        n_seg     = seg_of(r_rate);
        n_seg_lo  = {1'b0, r_seg};
        n_seg_hi  = 4'(n_seg_lo + 4'd1);
    end

    // Divider operand selection; each product lands in the divider register
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_LO: begin
                n_dividend = DIV_NW'(brk_num(n_seg_lo)) * DIV_NW'(r_half);
                n_divisor  = DIV_DW'(brk_den(n_seg_lo));
            end
            MUL_HI: begin
                n_dividend = DIV_NW'(brk_num(n_seg_hi)) * DIV_NW'(r_half);
                n_divisor  = DIV_DW'(brk_den(n_seg_hi));
            end
            MUL_INT: begin
                // dv * (hi - lo) stays below 2^24 over the whole curve
                n_dividend = DIV_NW'(r_dv) * DIV_NW'(r_hi - r_lo);
                n_divisor  = DIV_DW'(brk_rate(n_seg_hi) - brk_rate(n_seg_lo));
            end
            default: begin
                n_dividend = r_div_q;
                n_divisor  = r_div_d;
            end
        endcase
    end

    // Quotient by reciprocal multiplication; any other divisor is one
    always_comb begin
        n_recip = '0;
        n_div_q = r_div_q;
        case (r_div_d)
            DIV_DW'(105): begin
                n_recip = RECIP_W'(r_div_q) * RECIP_W'(RECIP_105);
                n_div_q = DIV_NW'(n_recip >> RECIP_105_SH);
            end
            DIV_DW'(500): begin
                n_recip = RECIP_W'(r_div_q[DIV_NW-1:2]) * RECIP_W'(RECIP_125);
                n_div_q = DIV_NW'(n_recip >> RECIP_125_SH);
            end
            DIV_DW'(1000): begin
                n_recip = RECIP_W'(r_div_q[DIV_NW-1:3]) * RECIP_W'(RECIP_125);
                n_div_q = DIV_NW'(n_recip >> RECIP_125_SH);
            end
            DIV_DW'(2000): begin
                n_recip = RECIP_W'(r_div_q[DIV_NW-1:4]) * RECIP_W'(RECIP_125);
                n_div_q = DIV_NW'(n_recip >> RECIP_125_SH);
            end
            default: ;
        endcase
    end

    // Goal from segment base plus interpolation, clamp and servo level
    always_comb begin
        n_pos     = r_lo + r_div_q[15:0];
        n_clamped = r_goal;
        if (n_clamped > r_upper) begin
            n_clamped = r_upper;
        end
        if (n_clamped < r_lower) begin
            n_clamped = r_lower;
        end
        n_mag = r_err[ERR_W-1] ? ERR_W'(-r_err) : r_err;
        n_win = (r_half[14:2] < 13'(WIN_MIN)) ? 13'(WIN_MIN) : r_half[14:2];
        n_lvl = (n_mag <= ERR_W'(n_win)) ? r_appr : r_full;
        n_fwd = !r_err[ERR_W-1] ^ r_invert;
    end

    // Item and servo state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ab <= '0;
            r_count   <= '0;
            r_goal    <= '0;
            r_lvl_fwd <= '0;
            r_lvl_rev <= '0;
        end else begin
            if (i_cmd.decode) begin
                r_count   <= n_count;
                r_prev_ab <= n_cur_ab;
            end
            if (i_cmd.goal) begin
                r_goal <= r_neg ? signed'(16'(-n_pos)) : signed'(n_pos);
            end
            if (i_cmd.clamp && r_enable) begin
                r_goal <= n_clamped;
            end
            if (i_cmd.level) begin
                r_lvl_fwd <= '0;
                r_lvl_rev <= '0;
                if (r_enable && (n_mag > ERR_W'(STOP_TOL))) begin
                    if (n_fwd) begin
                        r_lvl_fwd <= n_lvl;
                    end else begin
                        r_lvl_rev <= n_lvl;
                    end
                end
            end
        end
    end

    // Working registers of the needle curve
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_in_data;
        end
        if (i_cmd.mul_rate) begin
            r_neg  <= n_neg;
            r_prod <= 28'(n_abs_raw) * 28'(RATE_FULL);
        end
        if (i_cmd.rate) begin
            r_rate <= n_rate;
        end
        if (i_cmd.seg) begin
            r_seg <= n_seg;
            r_dv  <= 11'(r_rate - brk_rate({1'b0, n_seg}));
        end
        if (i_cmd.cap_lo) begin
            r_lo <= r_div_q[15:0];
        end
        if (i_cmd.cap_hi) begin
            r_hi <= r_div_q[15:0];
        end
        if (i_cmd.err) begin
            r_err <= ERR_W'(r_goal) - ERR_W'($signed(r_count));
        end
    end

    // Divider registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.mul_sel != MUL_NONE) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= DIV_CW'(r_div_cnt + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_div_q <= n_dividend;
            r_div_d <= n_divisor;
        end else if (i_cmd.div_step) begin
            r_div_q <= n_div_q;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.drive_fwd <= r_lvl_fwd;
            r_out.drive_rev <= r_lvl_rev;
            r_out.position  <= 32'($signed(r_count));
            r_out.target    <= 32'(r_goal);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;
    assign o_sts.enable   = r_enable;
    assign o_sts.div_done = (r_div_cnt == DIV_CW'(DIV_STEPS));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

endmodule
